// ===== hw/rtl/tsd_pkg.sv =====
// Package for the two-stack deque: sizes, action and status codes, request and
// response payload structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsd_pkg;

   localparam int STACK_DEPTH = 256;
   localparam int DATA_WIDTH  = 32;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int TOT_W  = CNT_W + 1;
   // wide enough for a stack count and for a 9-bit position
   localparam int IDX_W  = ((CNT_W > 9) ? CNT_W : 9) + 1;

   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_REAR  = 3'd1,
      ACT_READ_AT    = 3'd2,
      ACT_READ_FRONT = 3'd3,
      ACT_READ_BACK  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] value;
      logic [8:0]  position;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  status;
      logic [9:0]  count;
      logic        is_empty;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/two_stack_deque.sv =====
// Two-stack deque top level: request decode, stack counters, response register.
// Depends on tsd_pkg and tsd_ram.
//
// Usage
//   A double-ended queue held as two stacks in two RAMs. Each request on the req_
//   channel (push front, push back, read at a logical index, read front, read back)
//   gives exactly one response on the rsp_ channel carrying the data read, a status
//   code, the element count after the request and an empty flag. Codes 5 to 7 leave
//   the queue alone and answer ok with zero data.
//   Response: valid in the cycle after the request is accepted, which is the cycle in
//   which the registered read data of the stack RAM appears.
//   Throughput: one request per cycle while req_stall is low. Each request makes at
//   most one access to one of the two RAMs, a read or a write, and a push updates a
//   counter; a write is visible to a read in the next cycle, so back-to-back requests need no interlock.
//   Reset: both stack counters and the response valid clear; the RAMs are not cleared
//   and need no clearing pass, as reads only reach entries below a stack's count.
//   Stall: while a response waits under rsp_stall, req_stall is raised and the RAM
//   read data and response fields hold; when the response is taken, a new request
//   is accepted in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module two_stack_deque
   import tsd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // stack counters
   logic [CNT_W-1:0] front_cnt_ff, front_cnt_in;
   logic [CNT_W-1:0] back_cnt_ff, back_cnt_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic             rd_ok_ff, rd_ok_in;
   logic             rd_front_ff, rd_front_in;

   // RAM ports
   logic                  fr_we, fr_re, bk_we, bk_re;
   logic [ADDR_W-1:0]     fr_waddr, fr_raddr, bk_waddr, bk_raddr;
   logic [DATA_WIDTH-1:0] wr_value;
   logic [DATA_WIDTH-1:0] fr_rdata, bk_rdata;

   logic             req_accept;
   logic [TOT_W-1:0] total_now;
   logic [IDX_W-1:0] pos_ext, front_ext, total_ext;
   logic [IDX_W-1:0] front_idx, back_idx;

   // hold requests off while an untaken response sits in the register
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign total_now = TOT_W'(front_cnt_ff) + TOT_W'(back_cnt_ff);
   assign pos_ext   = IDX_W'(req_data.position);
   assign front_ext = IDX_W'(front_cnt_ff);
   assign total_ext = IDX_W'(total_now);
   // front stack is read from its top downward, back stack from its bottom upward
   assign front_idx = front_ext - IDX_W'(1) - pos_ext;
   assign back_idx  = pos_ext - front_ext;
   assign wr_value  = DATA_WIDTH'(req_data.value);

   always_comb begin
      front_cnt_in = front_cnt_ff;
      back_cnt_in  = back_cnt_ff;
      status_in    = status_ff;
      rd_ok_in     = rd_ok_ff;
      rd_front_in  = rd_front_ff;
      fr_we        = 1'b0;
      fr_re        = 1'b0;
      bk_we        = 1'b0;
      bk_re        = 1'b0;
      fr_waddr     = front_cnt_ff[ADDR_W-1:0];
      bk_waddr     = back_cnt_ff[ADDR_W-1:0];
      fr_raddr     = '0;
      bk_raddr     = '0;

      if (req_accept) begin
         status_in   = STATUS_OK;
         rd_ok_in    = 1'b0;
         rd_front_in = 1'b0;
         unique case (req_data.action)
            ACT_PUSH_FRONT: begin
               // drop the push on a full stack, never spill into the other one
               if (front_cnt_ff == CNT_W'(STACK_DEPTH)) begin
                  status_in = STATUS_FULL;
               end else begin
                  fr_we        = 1'b1;
                  front_cnt_in = front_cnt_ff + CNT_W'(1);
               end
            end
            ACT_PUSH_REAR: begin
               if (back_cnt_ff == CNT_W'(STACK_DEPTH)) begin
                  status_in = STATUS_FULL;
               end else begin
                  bk_we       = 1'b1;
                  back_cnt_in = back_cnt_ff + CNT_W'(1);
               end
            end
            ACT_READ_AT: begin
               if (pos_ext >= total_ext) begin
                  status_in = STATUS_RANGE;
               end else if (pos_ext < front_ext) begin
                  fr_re       = 1'b1;
                  fr_raddr    = front_idx[ADDR_W-1:0];
                  rd_ok_in    = 1'b1;
                  rd_front_in = 1'b1;
               end else begin
                  bk_re    = 1'b1;
                  bk_raddr = back_idx[ADDR_W-1:0];
                  rd_ok_in = 1'b1;
               end
            end
            ACT_READ_FRONT: begin
               // with the front stack empty, the front is the bottom of the back stack
               if (total_now == '0) begin
                  status_in = STATUS_EMPTY;
               end else if (front_cnt_ff != '0) begin
                  fr_re       = 1'b1;
                  fr_raddr    = front_idx[ADDR_W-1:0] + pos_ext[ADDR_W-1:0];
                  rd_ok_in    = 1'b1;
                  rd_front_in = 1'b1;
               end else begin
                  bk_re    = 1'b1;
                  rd_ok_in = 1'b1;
               end
            end
            ACT_READ_BACK: begin
               // with the back stack empty, the back is the bottom of the front stack
               if (total_now == '0) begin
                  status_in = STATUS_EMPTY;
               end else if (back_cnt_ff != '0) begin
                  bk_re    = 1'b1;
                  bk_raddr = back_cnt_ff[ADDR_W-1:0] - ADDR_W'(1);
                  rd_ok_in = 1'b1;
               end else begin
                  fr_re       = 1'b1;
                  rd_ok_in    = 1'b1;
                  rd_front_in = 1'b1;
               end
            end
            default: begin
               // unused codes: leave the queue alone, answer ok with zero data
            end
         endcase
      end
   end

   assign total_in = TOT_W'(front_cnt_in) + TOT_W'(back_cnt_in);

   always_comb begin
      priority if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_cnt_ff <= '0;
         back_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_cnt_ff <= front_cnt_in;
         back_cnt_ff  <= back_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response fields: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_accept) begin
         status_ff   <= status_in;
         total_ff    <= total_in;
         rd_ok_ff    <= rd_ok_in;
         rd_front_ff <= rd_front_in;
      end
   end

   tsd_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_front_ram (
      .clock   (clock),
      .wr_en   (fr_we),
      .wr_addr (fr_waddr),
      .wr_data (wr_value),
      .rd_en   (fr_re),
      .rd_addr (fr_raddr),
      .rd_data (fr_rdata)
   );

   tsd_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_back_ram (
      .clock   (clock),
      .wr_en   (bk_we),
      .wr_addr (bk_waddr),
      .wr_data (wr_value),
      .rd_en   (bk_re),
      .rd_addr (bk_raddr),
      .rd_data (bk_rdata)
   );

   // drive the response; RAM read data is selected only for a successful read
   always_comb begin
      rsp_data.read_data = '0;
      if (rd_ok_ff) begin
         rsp_data.read_data = rd_front_ff ? 32'(fr_rdata) : 32'(bk_rdata);
      end
      rsp_data.status   = status_ff;
      rsp_data.count    = 10'(total_ff);
      rsp_data.is_empty = (total_ff == '0);
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------- assertions

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_cnt_ff <= CNT_W'(STACK_DEPTH))
      else $error("front stack count beyond depth");

   a_back_bound: assert property (@(posedge clock) disable iff (reset)
      back_cnt_ff <= CNT_W'(STACK_DEPTH))
      else $error("back stack count beyond depth");

   a_front_push: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.action == ACT_PUSH_FRONT
      && front_cnt_ff != CNT_W'(STACK_DEPTH)
      |=> front_cnt_ff == $past(front_cnt_ff) + CNT_W'(1)
          && back_cnt_ff == $past(back_cnt_ff))
      else $error("front push did not advance only the front count");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != STATUS_OK |-> rsp_data.read_data == '0)
      else $error("failed request returned non-zero data");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff && total_ff == $past(total_in))
      else $error("accepted request gave no response");

endmodule

`default_nettype wire

// ===== hw/rtl/tsd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold read data unless a new read is issued
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
